// File: rtl/uds_pkg.sv
package uds_pkg;

   // Phase codes of the supervisor.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CONNECT = 3'd1;
   localparam logic [2:0] PH_STREAM  = 3'd2;
   localparam logic [2:0] PH_FINAL   = 3'd3;
   localparam logic [2:0] PH_RETRY   = 3'd4;
   localparam logic [2:0] PH_RESTART = 3'd5;

   // Result event codes.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_START    = 3'd1;
   localparam logic [2:0] EV_BEGUN    = 3'd2;
   localparam logic [2:0] EV_PROGRESS = 3'd3;
   localparam logic [2:0] EV_RETRY    = 3'd4;
   localparam logic [2:0] EV_ERROR    = 3'd5;
   localparam logic [2:0] EV_SUCCESS  = 3'd6;
   localparam logic [2:0] EV_RESTART  = 3'd7;

   // Reason codes.
   localparam logic [3:0] RS_NONE       = 4'd0;
   localparam logic [3:0] RS_BAD_URL    = 4'd1;
   localparam logic [3:0] RS_BUSY       = 4'd2;
   localparam logic [3:0] RS_LINK_CONN  = 4'd3;
   localparam logic [3:0] RS_SESSION    = 4'd4;
   localparam logic [3:0] RS_HTTP       = 4'd5;
   localparam logic [3:0] RS_LENGTH     = 4'd6;
   localparam logic [3:0] RS_FLASH_BEG  = 4'd7;
   localparam logic [3:0] RS_DIGEST     = 4'd8;
   localparam logic [3:0] RS_LINK_STRM  = 4'd9;
   localparam logic [3:0] RS_NO_STREAM  = 4'd10;
   localparam logic [3:0] RS_WRITE      = 4'd11;
   localparam logic [3:0] RS_CLOSED     = 4'd12;
   localparam logic [3:0] RS_TIMEOUT    = 4'd13;
   localparam logic [3:0] RS_SIZE       = 4'd14;
   localparam logic [3:0] RS_FINALIZE   = 4'd15;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RETRY_LIMIT = 3'd0;
   localparam logic [2:0] CSR_BASE        = 3'd1;
   localparam logic [2:0] CSR_CAP         = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd3;
   localparam logic [2:0] CSR_RESTART     = 3'd4;

   localparam logic [7:0] PCT_NONE = 8'hFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the input transaction, evaluate the step
      logic div_start;  // begin the percent division
      logic div_step;   // one quotient bit
      logic commit;     // update the stored percent and the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_last;
   } sts_type;

endpackage

// File: rtl/uds_datapath.sv
module uds_datapath #(
   parameter int MAX_CHUNK = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uds_pkg::cmd_type     cmd,
   output uds_pkg::sts_type     sts,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 req_op,
   input  logic [31:0]          req_now_ms,
   input  logic                 req_url_ok,
   input  logic                 req_link_up,
   input  logic                 req_session_ok,
   input  logic                 req_status_ok,
   input  logic signed [31:0]   req_content_length,
   input  logic [1:0]           req_flash_setup,
   input  logic [10:0]          req_chunk_bytes,
   input  logic                 req_write_ok,
   input  logic                 req_peer_connected,
   input  logic                 req_finish_ok,
   output logic [2:0]           rsp_event_res,
   output logic [6:0]           rsp_progress_pct,
   output logic [3:0]           rsp_reason_code,
   output logic [19:0]          rsp_delay_ms,
   output logic                 rsp_accepted,
   output logic                 rsp_busy_res
);

   localparam logic [32:0] CHUNK_MAX = 33'(MAX_CHUNK);

   // Configuration registers.
   logic [3:0]  retry_limit_ff;
   logic [15:0] base_ff;
   logic [19:0] cap_ff;
   logic [19:0] timeout_ff;
   logic [15:0] restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 4'd5;
         base_ff        <= 16'd2000;
         cap_ff         <= 20'd60000;
         timeout_ff     <= 20'd10000;
         restart_ff     <= 16'd800;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uds_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_data[3:0];
            uds_pkg::CSR_BASE:        base_ff        <= csr_data[15:0];
            uds_pkg::CSR_CAP:         cap_ff         <= csr_data[19:0];
            uds_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_data[19:0];
            uds_pkg::CSR_RESTART:     restart_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Supervisor state.
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  retries_ff, retries_in;
   logic [31:0] due_ff, due_in;
   logic [31:0] last_data_ff, last_data_in;
   logic [30:0] expected_ff, expected_in;
   logic [31:0] written_ff, written_in;
   logic [7:0]  last_pct_ff, last_pct_in;

   // Pending step result, held while the division runs.
   logic [2:0]  p_ev_ff, p_ev_in;
   logic [6:0]  p_pct_ff, p_pct_in;
   logic [3:0]  p_reason_ff, p_reason_in;
   logic [19:0] p_delay_ff, p_delay_in;
   logic        p_acc_ff, p_acc_in;
   logic        p_div_ff, p_div_in;

   // Restoring divider: dividend written*100 (39 bits) by expected.
   logic [38:0] quo_ff;
   logic [31:0] rem_ff;
   logic [5:0]  cnt_ff;

   // Step evaluation on the captured input.
   logic [31:0] now;
   logic [3:0]  why;
   logic        do_retry;
   logic [31:0] wait_shift;
   logic [19:0] wait_ms;
   logic [32:0] chunk;
   logic [32:0] sum;
   logic [6:0]  known_pct;

   always_comb begin
      now = req_now_ms;
      known_pct = (last_pct_ff == uds_pkg::PCT_NONE) ? 7'd0 : last_pct_ff[6:0];
      // A 16-bit base shifted by at most 15 always fits in 32 bits.
      wait_shift = {16'd0, base_ff} << retries_ff;
      if (wait_shift > {12'd0, cap_ff})
         wait_ms = cap_ff;
      else
         wait_ms = wait_shift[19:0];
      chunk = {22'd0, req_chunk_bytes};
      if (chunk > CHUNK_MAX) chunk = CHUNK_MAX;
      sum = {1'b0, written_ff} + chunk;

      phase_in = phase_ff; retries_in = retries_ff; due_in = due_ff;
      last_data_in = last_data_ff; expected_in = expected_ff;
      written_in = written_ff; last_pct_in = last_pct_ff;
      p_ev_in = uds_pkg::EV_NONE; p_pct_in = known_pct; p_reason_in = uds_pkg::RS_NONE;
      p_delay_in = 20'd0; p_acc_in = 1'b0; p_div_in = 1'b0;
      why = uds_pkg::RS_NONE; do_retry = 1'b0;

      if (req_op) begin
         if (!req_url_ok) begin
            p_ev_in = uds_pkg::EV_ERROR; p_pct_in = 7'd0; p_reason_in = uds_pkg::RS_BAD_URL;
         end else if (phase_ff != uds_pkg::PH_IDLE) begin
            p_ev_in = uds_pkg::EV_ERROR; p_reason_in = uds_pkg::RS_BUSY;
         end else begin
            retries_in = 4'd0; expected_in = 31'd0; written_in = 32'd0;
            last_pct_in = uds_pkg::PCT_NONE; due_in = now; phase_in = uds_pkg::PH_CONNECT;
            p_ev_in = uds_pkg::EV_START; p_pct_in = 7'd0; p_acc_in = 1'b1;
         end
      end else begin
         case (phase_ff)
            uds_pkg::PH_CONNECT: begin
               if (!req_link_up) begin do_retry = 1'b1; why = uds_pkg::RS_LINK_CONN; end
               else if (!req_session_ok) begin do_retry = 1'b1; why = uds_pkg::RS_SESSION; end
               else if (!req_status_ok) begin do_retry = 1'b1; why = uds_pkg::RS_HTTP; end
               else if (req_content_length <= 0) begin
                  do_retry = 1'b1; why = uds_pkg::RS_LENGTH;
               end else if (req_flash_setup != 2'd0) begin
                  expected_in = 31'd0; written_in = 32'd0; last_pct_in = uds_pkg::PCT_NONE;
                  phase_in = uds_pkg::PH_IDLE;
                  p_ev_in = uds_pkg::EV_ERROR; p_pct_in = 7'd0;
                  p_reason_in = (req_flash_setup == 2'd1) ? uds_pkg::RS_FLASH_BEG
                                                          : uds_pkg::RS_DIGEST;
               end else begin
                  expected_in = req_content_length[30:0]; written_in = 32'd0;
                  last_data_in = now; last_pct_in = 8'd0; phase_in = uds_pkg::PH_STREAM;
                  p_ev_in = uds_pkg::EV_BEGUN; p_pct_in = 7'd0;
               end
            end
            uds_pkg::PH_STREAM: begin
               if (!req_link_up) begin do_retry = 1'b1; why = uds_pkg::RS_LINK_STRM; end
               else if (!req_session_ok) begin do_retry = 1'b1; why = uds_pkg::RS_NO_STREAM; end
               else if (chunk != 33'd0) begin
                  if (!req_write_ok) begin do_retry = 1'b1; why = uds_pkg::RS_WRITE; end
                  else begin
                     written_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                     last_data_in = now;
                     p_div_in = 1'b1;   // percent finished after the division
                  end
               end else if (written_ff >= {1'b0, expected_ff}) begin
                  phase_in = uds_pkg::PH_FINAL;
               end else if (!req_peer_connected) begin
                  do_retry = 1'b1; why = uds_pkg::RS_CLOSED;
               end else if ((now - last_data_ff) > {12'd0, timeout_ff}) begin
                  do_retry = 1'b1; why = uds_pkg::RS_TIMEOUT;
               end
            end
            uds_pkg::PH_FINAL: begin
               if (written_ff != {1'b0, expected_ff}) begin
                  do_retry = 1'b1; why = uds_pkg::RS_SIZE;
               end else if (!req_finish_ok) begin
                  do_retry = 1'b1; why = uds_pkg::RS_FINALIZE;
               end else begin
                  last_pct_in = 8'd100; due_in = now + {16'd0, restart_ff};
                  phase_in = uds_pkg::PH_RESTART;
                  p_ev_in = uds_pkg::EV_SUCCESS; p_pct_in = 7'd100;
               end
            end
            uds_pkg::PH_RETRY: begin
               if (!(now - due_ff >= 32'h8000_0000)) phase_in = uds_pkg::PH_CONNECT;
            end
            uds_pkg::PH_RESTART: begin
               if (!(now - due_ff >= 32'h8000_0000)) begin
                  phase_in = uds_pkg::PH_IDLE; retries_in = 4'd0; due_in = 32'd0;
                  last_data_in = 32'd0; expected_in = 31'd0; written_in = 32'd0;
                  last_pct_in = uds_pkg::PCT_NONE;
                  p_ev_in = uds_pkg::EV_RESTART; p_pct_in = 7'd100;
               end
            end
            default: ;
         endcase
         if (do_retry) begin
            expected_in = 31'd0; written_in = 32'd0; last_pct_in = uds_pkg::PCT_NONE;
            p_pct_in = 7'd0; p_reason_in = why;
            if (retries_ff >= retry_limit_ff) begin
               phase_in = uds_pkg::PH_IDLE; p_ev_in = uds_pkg::EV_ERROR;
            end else begin
               retries_in = retries_ff + 4'd1; due_in = now + {12'd0, wait_ms};
               phase_in = uds_pkg::PH_RETRY; p_ev_in = uds_pkg::EV_RETRY;
               p_delay_in = wait_ms;
            end
         end
      end
   end

   // Divider step.
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[38]} - {2'b0, expected_ff};

   logic [7:0] pct_new;
   always_comb begin
      if (expected_ff == 31'd0 || quo_ff > 39'd100) pct_new = 8'd100;
      else pct_new = quo_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uds_pkg::PH_IDLE; retries_ff <= 4'd0; due_ff <= 32'd0;
         last_data_ff <= 32'd0; expected_ff <= 31'd0; written_ff <= 32'd0;
         last_pct_ff <= uds_pkg::PCT_NONE; p_div_ff <= 1'b0; cnt_ff <= 6'd0;
      end else begin
         if (cmd.load) begin
            phase_ff <= phase_in; retries_ff <= retries_in; due_ff <= due_in;
            last_data_ff <= last_data_in; expected_ff <= expected_in;
            written_ff <= written_in; last_pct_ff <= last_pct_in; p_div_ff <= p_div_in;
         end
         if (cmd.div_start) begin
            quo_ff <= 39'({7'd0, written_ff} * 39'd100);
            rem_ff <= 32'd0; cnt_ff <= 6'd0;
         end
         if (cmd.div_step) begin
            if (!trial[32]) begin
               rem_ff <= trial[31:0]; quo_ff <= {quo_ff[37:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[30:0], quo_ff[38]}; quo_ff <= {quo_ff[37:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (cmd.commit && p_div_ff) begin
            if (pct_new != last_pct_ff) last_pct_ff <= pct_new;
         end
      end
   end

   // Pending result registers, payload only.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ev_ff <= p_ev_in; p_pct_ff <= p_pct_in; p_reason_ff <= p_reason_in;
         p_delay_ff <= p_delay_in; p_acc_ff <= p_acc_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (p_div_ff) begin
            rsp_event_res <= (pct_new != last_pct_ff) ? uds_pkg::EV_PROGRESS
                                                      : uds_pkg::EV_NONE;
            rsp_progress_pct <= pct_new[6:0];
         end else begin
            rsp_event_res <= p_ev_ff; rsp_progress_pct <= p_pct_ff;
         end
         rsp_reason_code <= p_reason_ff; rsp_delay_ms <= p_delay_ff;
         rsp_accepted <= p_acc_ff; rsp_busy_res <= (phase_ff != uds_pkg::PH_IDLE);
      end
   end

   assign sts.need_div = p_div_ff;
   assign sts.div_last = (cnt_ff == 6'd38);

endmodule

// File: rtl/uds_ctrl.sv
module uds_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               csr_ready,
   output uds_pkg::cmd_type   cmd,
   input  uds_pkg::sts_type   sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of one transaction.
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1; state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1; state_in = ST_DIV;
            end else state_in = ST_COMMIT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1; state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/update_download_supervisor.sv
// Channel   Direction  Handshake             Contents
// req_      in         req_valid/req_ready   op, time and step outcomes
// rsp_      out        rsp_valid/rsp_ready   event, percent, reason, delay, flags
// csr_      in         csr_valid/csr_ready   register index and write data
// The result is offered once a transaction has passed the CHECK, COMMIT and OUT
// states; with a data chunk DIV comes between CHECK and COMMIT, and the percent is
// formed there by a one-bit-per-cycle restoring divider of 39 steps. One
// transaction is in flight at a time; the next is taken after the result has been
// accepted, so a stalled receiver stalls the input. Reset is synchronous and
// restores the register defaults.
module update_download_supervisor #(
   parameter int MAX_CHUNK = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [31:0]        req_now_ms,
   input  logic               req_url_ok,
   input  logic               req_link_up,
   input  logic               req_session_ok,
   input  logic               req_status_ok,
   input  logic signed [31:0] req_content_length,
   input  logic [1:0]         req_flash_setup,
   input  logic [10:0]        req_chunk_bytes,
   input  logic               req_write_ok,
   input  logic               req_peer_connected,
   input  logic               req_finish_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_res,
   output logic [6:0]         rsp_progress_pct,
   output logic [3:0]         rsp_reason_code,
   output logic [19:0]        rsp_delay_ms,
   output logic               rsp_accepted,
   output logic               rsp_busy_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   uds_pkg::cmd_type cmd;
   uds_pkg::sts_type sts;

   uds_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .csr_ready, .cmd, .sts
   );

   uds_datapath #(.MAX_CHUNK(MAX_CHUNK)) u_dp (
      .clock, .reset, .cmd, .sts, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_op, .req_now_ms, .req_url_ok, .req_link_up, .req_session_ok,
      .req_status_ok, .req_content_length, .req_flash_setup, .req_chunk_bytes,
      .req_write_ok, .req_peer_connected, .req_finish_ok,
      .rsp_event_res, .rsp_progress_pct, .rsp_reason_code, .rsp_delay_ms,
      .rsp_accepted, .rsp_busy_res
   );

endmodule
